// ===== src/ppc_pkg.sv =====
// Package for the single-plane polygon clipper: widths, the op record that
// crosses from front to back, the result record and state types.
// No dependencies.
package ppc_pkg;

	localparam int CoordW = 32;                 // coordinate width, Q16.16
	localparam int CoefW  = 32;                 // plane register width
	localparam int ProdW  = CoefW + CoordW;     // one distance product
	localparam int DistW  = ProdW + 3;          // sum of three products and offset
	localparam int DenW   = DistW + 1;          // |dP - dC|
	localparam int RemW   = DenW + 1;           // divider remainder
	localparam int TW     = 32;                 // t, unsigned Q0.32
	localparam int IpW    = TW + CoordW + 2;    // t * (C - P)
	localparam int OffSh  = 16;                 // plane_d is aligned to Q32.32

	typedef enum logic [1:0] {
		REG_PLANE_A = 2'd0,
		REG_PLANE_B = 2'd1,
		REG_PLANE_C = 2'd2,
		REG_PLANE_D = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_PUSH
	} f_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EMIT_P,
		B_DIV,
		B_MUL,
		B_EMIT_X,
		B_CLOSE
	} b_state_t;

	typedef struct packed {
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic signed [CoordW-1:0] pz;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] cz;
		logic [DistW-1:0]         dp_abs;
		logic [DenW-1:0]          den;
		logic                     p_front;
		logic                     crosses;
		logic                     last;
		logic                     lone;
	} op_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic                     closing_copy;
		logic                     polygon_empty;
		logic                     end_of_polygon;
	} res_t;

	typedef struct packed {
		logic signed [CoefW-1:0] a;
		logic signed [CoefW-1:0] b;
		logic signed [CoefW-1:0] c;
		logic signed [CoefW-1:0] d;
	} plane_t;

endpackage

// ===== src/ppc_front.sv =====
// Front part of the clipper: takes vertices, forms both plane distances of
// each edge with one shared multiplier and classifies the edge.
// Depends on ppc_pkg.
module ppc_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ppc_pkg::plane_t                    plane,
	input  logic                               push,
	output logic                               full,
	input  logic signed [ppc_pkg::CoordW-1:0]  vert_x,
	input  logic signed [ppc_pkg::CoordW-1:0]  vert_y,
	input  logic signed [ppc_pkg::CoordW-1:0]  vert_z,
	input  logic                               last_vertex,
	output logic                               op_push,
	output ppc_pkg::op_t                       op,
	input  logic                               op_full
);
	ppc_pkg::f_state_t state_q, state_d;
	logic signed [ppc_pkg::CoordW-1:0] cx_q, cy_q, cz_q, px_q, py_q, pz_q;
	logic last_q, lone_q, have_prev_q;
	logic signed [ppc_pkg::DistW-1:0] dp_q, dn_q, dterm;
	logic signed [ppc_pkg::ProdW-1:0] prod_s1;
	logic [2:0] cnt_q;
	logic signed [ppc_pkg::CoefW-1:0] m_coef;
	logic signed [ppc_pkg::CoordW-1:0] m_coord;
	logic accept;
	logic signed [ppc_pkg::DenW-1:0] ddiff;

	assign full   = (state_q != ppc_pkg::F_IDLE);
	assign accept = push && !full;
	assign dterm  = {{(ppc_pkg::DistW - ppc_pkg::CoefW - ppc_pkg::OffSh){plane.d[ppc_pkg::CoefW-1]}},
		plane.d, {ppc_pkg::OffSh{1'b0}}};

	always_comb begin
		unique case (cnt_q)
			3'd0: begin m_coef = plane.a; m_coord = px_q; end
			3'd1: begin m_coef = plane.b; m_coord = py_q; end
			3'd2: begin m_coef = plane.c; m_coord = pz_q; end
			3'd3: begin m_coef = plane.a; m_coord = cx_q; end
			3'd4: begin m_coef = plane.b; m_coord = cy_q; end
			3'd5: begin m_coef = plane.c; m_coord = cz_q; end
			default: begin m_coef = '0; m_coord = '0; end
		endcase
	end

	always_comb begin
		ddiff      = {dp_q[ppc_pkg::DistW-1], dp_q} - {dn_q[ppc_pkg::DistW-1], dn_q};
		op.px      = px_q;
		op.py      = py_q;
		op.pz      = pz_q;
		op.cx      = cx_q;
		op.cy      = cy_q;
		op.cz      = cz_q;
		op.dp_abs  = dp_q[ppc_pkg::DistW-1] ? ppc_pkg::DistW'(-dp_q) : ppc_pkg::DistW'(dp_q);
		op.den     = ddiff[ppc_pkg::DenW-1] ? ppc_pkg::DenW'(-ddiff) : ppc_pkg::DenW'(ddiff);
		op.p_front = !dp_q[ppc_pkg::DistW-1] && (dp_q != '0);
		op.crosses = op.p_front ? dn_q[ppc_pkg::DistW-1]
			: (!dn_q[ppc_pkg::DistW-1] && (dn_q != '0));
		op.last    = last_q;
		op.lone    = lone_q;
	end

	always_comb begin
		state_d = state_q;
		op_push = 1'b0;
		unique case (state_q)
			ppc_pkg::F_IDLE: begin
				if (accept) begin
					if (have_prev_q)
						state_d = ppc_pkg::F_MUL;
					else if (last_vertex)
						state_d = ppc_pkg::F_PUSH;
				end
			end
			ppc_pkg::F_MUL: begin
				if (cnt_q == 3'd6)
					state_d = ppc_pkg::F_PUSH;
			end
			ppc_pkg::F_PUSH: begin
				if (!op_full) begin
					op_push = 1'b1;
					state_d = ppc_pkg::F_IDLE;
				end
			end
			default: state_d = ppc_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppc_pkg::F_IDLE;
			have_prev_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !have_prev_q && !last_vertex) begin
				px_q        <= vert_x;
				py_q        <= vert_y;
				pz_q        <= vert_z;
				have_prev_q <= 1'b1;
			end
			if (op_push) begin
				px_q        <= cx_q;
				py_q        <= cy_q;
				pz_q        <= cz_q;
				have_prev_q <= !last_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q   <= vert_x;
			cy_q   <= vert_y;
			cz_q   <= vert_z;
			last_q <= last_vertex;
			lone_q <= !have_prev_q;
			cnt_q  <= '0;
			dp_q   <= dterm;
			dn_q   <= dterm;
		end else if (state_q == ppc_pkg::F_MUL) begin
			cnt_q   <= cnt_q + 3'd1;
			prod_s1 <= m_coef * m_coord;
			if (cnt_q >= 3'd1 && cnt_q <= 3'd3)
				dp_q <= dp_q + ppc_pkg::DistW'(prod_s1);
			else if (cnt_q >= 3'd4)
				dn_q <= dn_q + ppc_pkg::DistW'(prod_s1);
		end
	end

endmodule

// ===== src/ppc_queue.sv =====
// Two-entry queue of classified edges between the front and back parts.
// Depends on ppc_pkg.
module ppc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ppc_pkg::op_t  wr_op,
	output logic          q_full,
	input  logic          rd_en,
	output ppc_pkg::op_t  rd_op,
	output logic          q_valid
);
	ppc_pkg::op_t mem [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign rd_op   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_ptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// ===== src/ppc_back.sv =====
// Back part of the clipper: emits front vertices, divides for t, forms the
// crossing point and closes the polygon; holds the output register.
// Depends on ppc_pkg.
module ppc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  ppc_pkg::op_t  op_in,
	output logic          op_pop,
	output ppc_pkg::res_t res,
	output logic          res_valid,
	input  logic          pop
);
	ppc_pkg::b_state_t state_q, state_d;
	ppc_pkg::op_t op_q;
	ppc_pkg::res_t res_q, res_d;
	logic res_valid_q, slot_free, emit, emit_vtx;
	logic [ppc_pkg::RemW-1:0] rem_q, rem2;
	logic ge;
	logic [ppc_pkg::TW-1:0] t_q;
	logic [4:0] dcnt_q;
	logic [1:0] mcnt_q;
	logic signed [ppc_pkg::IpW-1:0] prod_s1;
	logic signed [ppc_pkg::CoordW:0] diff;
	logic signed [ppc_pkg::CoordW-1:0] p_sel, ix_q, iy_q, iz_q, fx_q, fy_q, fz_q, ires;
	logic have_out_q;

	assign res       = res_q;
	assign res_valid = res_valid_q;
	assign slot_free = !res_valid_q || pop;

	assign rem2 = {rem_q[ppc_pkg::RemW-2:0], 1'b0};
	assign ge   = (op_q.den != '0) && (rem2 >= ppc_pkg::RemW'(op_q.den));

	always_comb begin
		unique case (mcnt_q)
			2'd0: begin
				diff  = {op_q.cx[ppc_pkg::CoordW-1], op_q.cx} - {op_q.px[ppc_pkg::CoordW-1], op_q.px};
				p_sel = op_q.px;
			end
			2'd1: begin
				diff  = {op_q.cy[ppc_pkg::CoordW-1], op_q.cy} - {op_q.py[ppc_pkg::CoordW-1], op_q.py};
				p_sel = op_q.px;
			end
			2'd2: begin
				diff  = {op_q.cz[ppc_pkg::CoordW-1], op_q.cz} - {op_q.pz[ppc_pkg::CoordW-1], op_q.pz};
				p_sel = op_q.py;
			end
			default: begin
				diff  = '0;
				p_sel = op_q.pz;
			end
		endcase
		// p_sel lags one step behind diff to pair with the registered product
		ires = p_sel + prod_s1[ppc_pkg::TW +: ppc_pkg::CoordW];
	end

	always_comb begin
		state_d  = state_q;
		op_pop   = 1'b0;
		emit     = 1'b0;
		emit_vtx = 1'b0;
		res_d    = '0;
		unique case (state_q)
			ppc_pkg::B_IDLE: begin
				if (op_valid) begin
					op_pop = 1'b1;
					priority if (op_in.lone)     state_d = ppc_pkg::B_CLOSE;
					else if (op_in.p_front)      state_d = ppc_pkg::B_EMIT_P;
					else if (op_in.crosses)      state_d = ppc_pkg::B_DIV;
					else if (op_in.last)         state_d = ppc_pkg::B_CLOSE;
					else                         state_d = ppc_pkg::B_IDLE;
				end
			end
			ppc_pkg::B_EMIT_P: begin
				res_d.x = op_q.px;
				res_d.y = op_q.py;
				res_d.z = op_q.pz;
				if (slot_free) begin
					emit     = 1'b1;
					emit_vtx = 1'b1;
					priority if (op_q.crosses) state_d = ppc_pkg::B_DIV;
					else if (op_q.last)        state_d = ppc_pkg::B_CLOSE;
					else                       state_d = ppc_pkg::B_IDLE;
				end
			end
			ppc_pkg::B_DIV: begin
				if (dcnt_q == 5'd31)
					state_d = ppc_pkg::B_MUL;
			end
			ppc_pkg::B_MUL: begin
				if (mcnt_q == 2'd3)
					state_d = ppc_pkg::B_EMIT_X;
			end
			ppc_pkg::B_EMIT_X: begin
				res_d.x = ix_q;
				res_d.y = iy_q;
				res_d.z = iz_q;
				if (slot_free) begin
					emit     = 1'b1;
					emit_vtx = 1'b1;
					state_d  = op_q.last ? ppc_pkg::B_CLOSE : ppc_pkg::B_IDLE;
				end
			end
			ppc_pkg::B_CLOSE: begin
				res_d.end_of_polygon = 1'b1;
				if (have_out_q) begin
					res_d.x            = fx_q;
					res_d.y            = fy_q;
					res_d.z            = fz_q;
					res_d.closing_copy = 1'b1;
				end else begin
					res_d.polygon_empty = 1'b1;
				end
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ppc_pkg::B_IDLE;
				end
			end
			default: state_d = ppc_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppc_pkg::B_IDLE;
			res_valid_q <= 1'b0;
			have_out_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
			if (emit_vtx)
				have_out_q <= 1'b1;
			else if (emit)
				have_out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q   <= op_in;
			rem_q  <= ppc_pkg::RemW'(op_in.dp_abs);
			dcnt_q <= '0;
			mcnt_q <= '0;
		end
		if (state_q == ppc_pkg::B_DIV) begin
			rem_q  <= ge ? rem2 - ppc_pkg::RemW'(op_q.den) : rem2;
			t_q    <= {t_q[ppc_pkg::TW-2:0], ge};
			dcnt_q <= dcnt_q + 5'd1;
		end
		if (state_q == ppc_pkg::B_MUL) begin
			mcnt_q  <= mcnt_q + 2'd1;
			prod_s1 <= $signed({1'b0, t_q}) * diff;
			unique case (mcnt_q)
				2'd1: ix_q <= ires;
				2'd2: iy_q <= ires;
				2'd3: iz_q <= ires;
				default: ;
			endcase
		end
		if (emit_vtx && !have_out_q) begin
			fx_q <= res_d.x;
			fy_q <= res_d.y;
			fz_q <= res_d.z;
		end
		if (emit)
			res_q <= res_d;
	end

endmodule

// ===== src/polygon_plane_clipper.sv =====
// Top level of the single-plane polygon clipper: plane registers, front,
// edge queue and back. Depends on ppc_pkg, ppc_front, ppc_queue, ppc_back.
//
// Clips one closed polygon against the plane a*x + b*y + c*z + d = 0, all
// in signed Q16.16. Push vertices in order with the first vertex repeated
// last and that repeat flagged by last_vertex. Each edge yields its start
// vertex if strictly in front of the plane, then the crossing point if the
// edge crosses; the flagged vertex adds a copy of the first output vertex,
// or an all-zero marker with polygon_empty set if nothing survived. The
// front part takes the first vertex of a polygon directly and passes every
// further vertex through its one multiplier, which forms the six distance
// products in turn. The back part emits an edge's start vertex, then for a
// crossing edge runs the 32-step restoring divider that forms t and the
// three interpolation products before it emits the crossing point; closing
// a polygon emits one more result. A two-entry queue between the parts
// lets the front run ahead. Results wait in a one-entry output register,
// and the back part stalls while it is occupied and not popped.
// Write the plane registers only while the block holds no unfinished work.
module polygon_plane_clipper (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [ppc_pkg::CoefW-1:0]          cfg_data,
	input  logic                               push,
	output logic                               full,
	input  logic signed [ppc_pkg::CoordW-1:0]  vert_x,
	input  logic signed [ppc_pkg::CoordW-1:0]  vert_y,
	input  logic signed [ppc_pkg::CoordW-1:0]  vert_z,
	input  logic                               last_vertex,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [ppc_pkg::CoordW-1:0]  out_x,
	output logic signed [ppc_pkg::CoordW-1:0]  out_y,
	output logic signed [ppc_pkg::CoordW-1:0]  out_z,
	output logic                               closing_copy,
	output logic                               polygon_empty,
	output logic                               end_of_polygon
);
	ppc_pkg::plane_t plane_q;
	ppc_pkg::op_t f_op, q_op;
	ppc_pkg::res_t res;
	logic f_push, q_full, q_valid, b_pop, res_valid;

	// Plane registers; reset to the plane z = 0 facing +z.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.a <= '0;
			plane_q.b <= '0;
			plane_q.c <= ppc_pkg::CoefW'(32'sd65536);
			plane_q.d <= '0;
		end else if (cfg_we) begin
			unique case (ppc_pkg::reg_idx_t'(cfg_index))
				ppc_pkg::REG_PLANE_A: plane_q.a <= cfg_data;
				ppc_pkg::REG_PLANE_B: plane_q.b <= cfg_data;
				ppc_pkg::REG_PLANE_C: plane_q.c <= cfg_data;
				ppc_pkg::REG_PLANE_D: plane_q.d <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: distances and classification of each edge.
	ppc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.plane       (plane_q),
		.push        (push),
		.full        (full),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.vert_z      (vert_z),
		.last_vertex (last_vertex),
		.op_push     (f_push),
		.op          (f_op),
		.op_full     (q_full)
	);

	// Hold classified edges until the back part is free.
	ppc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_op   (f_op),
		.q_full  (q_full),
		.rd_en   (b_pop),
		.rd_op   (q_op),
		.q_valid (q_valid)
	);

	// Back: divide, interpolate, emit and close.
	ppc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_valid),
		.op_in     (q_op),
		.op_pop    (b_pop),
		.res       (res),
		.res_valid (res_valid),
		.pop       (pop)
	);

	assign empty          = !res_valid;
	assign out_x          = res.x;
	assign out_y          = res.y;
	assign out_z          = res.z;
	assign closing_copy   = res.closing_copy;
	assign polygon_empty  = res.polygon_empty;
	assign end_of_polygon = res.end_of_polygon;

endmodule

// ===== src/ppc_checker.sv =====
// Port-level checks for the polygon clipper, bound to the top level.
// Depends on ppc_pkg and polygon_plane_clipper.
module ppc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               empty,
	input logic                               pop,
	input logic signed [ppc_pkg::CoordW-1:0]  out_x,
	input logic signed [ppc_pkg::CoordW-1:0]  out_y,
	input logic signed [ppc_pkg::CoordW-1:0]  out_z,
	input logic                               closing_copy,
	input logic                               polygon_empty,
	input logic                               end_of_polygon
);
	// An empty marker ends the polygon and carries no vertex.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && polygon_empty) |->
			(end_of_polygon && !closing_copy && out_x == '0 && out_y == '0 && out_z == '0))
		else $error("empty marker malformed");

	// The closing copy is always the final result of its polygon.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && closing_copy) |-> end_of_polygon)
		else $error("closing copy without end of polygon");

	// Every end of polygon is either a closing copy or an empty marker.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_polygon) |-> (closing_copy != polygon_empty))
		else $error("end of polygon neither copy nor marker");

	// Hold a waiting result until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_x) && $stable(out_y) && $stable(out_z)))
		else $error("waiting result changed");

endmodule

bind polygon_plane_clipper ppc_checker u_ppc_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for polygon_plane_clipper: vertex streams are pushed
// into the clipper, results are popped and compared with a local model.
// Depends on ppc_pkg and the clipper RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [ppc_pkg::CoefW-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic signed [ppc_pkg::CoordW-1:0] vert_x = '0, vert_y = '0, vert_z = '0;
	logic last_vertex = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [ppc_pkg::CoordW-1:0] out_x, out_y, out_z;
	logic closing_copy, polygon_empty, end_of_polygon;

	polygon_plane_clipper uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// model state: plane, previous vertex and first output vertex
	logic signed [31:0] pl_a = 0, pl_b = 0, pl_c = 32'sd65536, pl_d = 0;
	logic signed [31:0] last_x = 0, last_y = 0, last_z = 0;
	logic signed [31:0] head_x = 0, head_y = 0, head_z = 0;
	logic open_poly = 1'b0, any_out = 1'b0;

	ppc_pkg::res_t expected_q[$];
	int mismatches = 0;
	bit quiet = 1'b0;   // no idling in the final stretch

	function automatic logic signed [95:0] plane_dist(logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic signed [95:0] s;
		s = 96'(pl_a) * 96'(x) + 96'(pl_b) * 96'(y) + 96'(pl_c) * 96'(z);
		return s + (96'(pl_d) <<< 16);
	endfunction

	function automatic logic signed [31:0] lerp(logic signed [31:0] p,
			logic signed [31:0] c, logic [32:0] t);
		logic signed [127:0] prod;
		prod = $signed({95'd0, t}) * (128'(c) - 128'(p));
		return p + 32'(prod >>> 32);
	endfunction

	task automatic queue_vertex(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		ppc_pkg::res_t r;
		r = '{x: x, y: y, z: z, default: 1'b0};
		if (!any_out) begin
			head_x = x; head_y = y; head_z = z;
			any_out = 1'b1;
		end
		expected_q = {expected_q, r};
	endtask

	task automatic queue_close();
		ppc_pkg::res_t r;
		if (any_out) r = '{x: head_x, y: head_y, z: head_z, closing_copy: 1'b1,
			polygon_empty: 1'b0, end_of_polygon: 1'b1};
		else r = '{x: 0, y: 0, z: 0, closing_copy: 1'b0, polygon_empty: 1'b1,
			end_of_polygon: 1'b1};
		expected_q = {expected_q, r};
	endtask

	// work out the results of one accepted vertex
	task automatic clip_step(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic lst);
		logic signed [95:0] dp, dn;
		logic [127:0] num, den;
		logic [32:0] t;
		logic p_front, crosses;
		if (!open_poly) begin
			last_x = x; last_y = y; last_z = z;
			open_poly = 1'b1;
			any_out = 1'b0;
			if (lst) begin
				queue_close();
				open_poly = 1'b0;
			end
			return;
		end
		dp = plane_dist(last_x, last_y, last_z);
		dn = plane_dist(x, y, z);
		p_front = dp > 0;
		crosses = p_front ? (dn < 0) : (dn > 0);
		if (p_front) queue_vertex(last_x, last_y, last_z);
		if (crosses) begin
			num = 128'(dp < 0 ? -dp : dp) << 32;
			den = 128'((dp - dn) < 0 ? -(dp - dn) : (dp - dn));
			t = (den == 0) ? 33'd0 : 33'(num / den);
			queue_vertex(lerp(last_x, x, t), lerp(last_y, y, t), lerp(last_z, z, t));
		end
		last_x = x; last_y = y; last_z = z;
		if (lst) begin
			queue_close();
			open_poly = 1'b0;
			any_out = 1'b0;
		end
	endtask

	task automatic idle_burst();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// send one vertex; hold push until the transaction completes
	task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic lst);
		idle_burst();
		push <= 1'b1;
		vert_x <= x; vert_y <= y; vert_z <= z; last_vertex <= lst;
		do @(posedge clk); while (full);
		clip_step(x, y, z, lst);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		// a trailing edge with no crossing may still be in flight
		repeat (60) @(posedge clk);
	endtask

	task automatic write_plane(ppc_pkg::reg_idx_t idx, logic signed [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ppc_pkg::REG_PLANE_A: pl_a = val;
			ppc_pkg::REG_PLANE_B: pl_b = val;
			ppc_pkg::REG_PLANE_C: pl_c = val;
			ppc_pkg::REG_PLANE_D: pl_d = val;
		endcase
	endtask

	task automatic set_plane(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d);
		drain();
		write_plane(ppc_pkg::REG_PLANE_A, a);
		write_plane(ppc_pkg::REG_PLANE_B, b);
		write_plane(ppc_pkg::REG_PLANE_C, c);
		write_plane(ppc_pkg::REG_PLANE_D, d);
	endtask

	function automatic logic signed [31:0] rnd_coord(int mode);
		case (mode)
			0: return $signed($urandom());
			1: return $signed(32'($urandom_range(0, 20)) << 16) - 32'sd655360;
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sd131072;
		endcase
	endfunction

	// one well-formed polygon with random vertices, closed by the first one
	task automatic send_polygon(int nv, int mode);
		logic signed [31:0] fx, fy, fz;
		fx = rnd_coord(mode); fy = rnd_coord(mode); fz = rnd_coord(mode);
		send_vertex(fx, fy, fz, 1'b0);
		for (int i = 1; i < nv; i++)
			send_vertex(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), 1'b0);
		send_vertex(fx, fy, fz, 1'b1);
	endtask

	task automatic send_polygon_fixed();
		send_vertex(0, 0, 32'sd65536, 1'b0);
		send_vertex(32'sd65536, 0, -32'sd65536, 1'b0);
		send_vertex(0, 32'sd65536, 0, 1'b0);
		send_vertex(0, 0, 32'sd65536, 1'b1);
	endtask

	task automatic test_directed();
		// lone flagged vertex: empty marker only
		send_vertex(32'sd5, -32'sd5, 32'sd7, 1'b1);
		// triangle crossing z = 0
		send_polygon_fixed();
		// all behind, vertex on the plane, extremes of coordinates
		send_vertex(0, 0, -32'sd65536, 1'b0);
		send_vertex(32'sh7fffffff, 32'sh80000000, 0, 1'b0);
		send_vertex(32'sh80000000, 32'sh7fffffff, -32'sd1, 1'b0);
		send_vertex(0, 0, -32'sd65536, 1'b1);
		send_vertex(0, 0, 32'sh7fffffff, 1'b0);
		send_vertex(0, 0, 32'sh80000000, 1'b0);
		send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sd1, 1'b0);
		send_vertex(0, 0, 32'sh7fffffff, 1'b1);
	endtask

	task automatic test_planes();
		set_plane(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_polygon(3, 0);
		send_polygon(4, 0);
		set_plane(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff);
		send_polygon(3, 0);
		set_plane(0, 0, 0, 0);  // every distance zero: nothing survives
		send_polygon(3, 2);
	endtask

	task automatic test_random();
		for (int k = 0; k < 88; k++) begin
			if (k % 12 == 0)
				set_plane($signed($urandom()) >>> $urandom_range(0, 16),
					$signed($urandom()) >>> $urandom_range(0, 16),
					$signed($urandom()) >>> $urandom_range(0, 16),
					$signed($urandom()) >>> $urandom_range(0, 20));
			if (k == 76) begin
				drain();
				quiet = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				send_vertex(rnd_coord(0), rnd_coord(0), rnd_coord(0), 1'b1);
			else
				send_polygon($urandom_range(1, 8), $urandom_range(0, 2));
		end
	endtask

	// pop side: random stalls, compare each transaction with the oldest expectation
	initial begin
		ppc_pkg::res_t e;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result x=%h", out_x);
				end else begin
					e = expected_q.pop_front();
					if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
							closing_copy !== e.closing_copy ||
							polygon_empty !== e.polygon_empty ||
							end_of_polygon !== e.end_of_polygon) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %h %h %h %b%b%b got %h %h %h %b%b%b",
								e.x, e.y, e.z, e.closing_copy, e.polygon_empty,
								e.end_of_polygon, out_x, out_y, out_z, closing_copy,
								polygon_empty, end_of_polygon);
					end
				end
			end
			if (!quiet && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else pop <= 1'b1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_planes();
		test_random();
		drain();
		if (mismatches == 0 && expected_q.size() == 0) $display("[polygon_plane_clipper] OK");
		else $display("[polygon_plane_clipper] ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("[polygon_plane_clipper] ERROR");
		$finish;
	end
endmodule
